// ----- hdl/bgpk_pkg.sv -----
`timescale 1ns / 1ps
// battery gauge and power key monitor: shared constants, codes and types
// no dependencies

package bgpk_pkg;

   // field widths fixed by the request and response formats
   localparam int SAMPLE_BITS   = 10;
   localparam int COUNT_BITS    = 10;
   localparam int CODE_BITS     = 10;
   localparam int LEVEL_BITS    = 4;
   localparam int CHARGE_BITS   = 2;
   localparam int ADC_MAX_BITS  = 14;

   // parameter defaults
   localparam int SAMPLES_PER_AVERAGE_DEFAULT = 9;
   localparam int ADC_BITS_DEFAULT            = 10;

   localparam logic [COUNT_BITS-1:0] PRESS_TICKS_RESET = 10'd200;

   // request kinds
   localparam logic ACTION_KEY     = 1'b0;
   localparam logic ACTION_MONITOR = 1'b1;

   // charge status codes
   localparam logic [CHARGE_BITS-1:0] CHARGE_NONE     = 2'd0;
   localparam logic [CHARGE_BITS-1:0] CHARGE_CHARGING = 2'd1;
   localparam logic [CHARGE_BITS-1:0] CHARGE_FULL     = 2'd2;

   // monitor tick schedule
   localparam int TICK_BITS     = 6;
   localparam int TICK_LAST     = 51;
   localparam int SAMPLE_PERIOD = 5;
   localparam int CHARGE_PERIOD = 11;
   localparam int PHASE5_BITS   = $clog2(SAMPLE_PERIOD);
   localparam int PHASE11_BITS  = $clog2(CHARGE_PERIOD);

   // level thresholds on the 10-bit code scale, lowest and highest bound the valid band
   localparam int LEVEL_STEPS = 9;
   localparam logic [CODE_BITS-1:0] LEVEL_TOP [LEVEL_STEPS] = '{
      10'd716, 10'd885, 10'd893, 10'd899, 10'd912, 10'd925, 10'd942, 10'd963, 10'd1002
   };

   typedef struct packed {
      logic [CHARGE_BITS-1:0] charge_status;
      logic [LEVEL_BITS-1:0]  battery_level;
      logic [CODE_BITS-1:0]   average_code;
   } bgpk_status_type;

endpackage

// ----- hdl/bgpk_if.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces, valid/ready handshake
// depends on bgpk_pkg

interface bgpk_req_if
   import bgpk_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic                   key_pressed;
   logic [SAMPLE_BITS-1:0] adc_sample;
   logic                   standby_pin;
   logic                   charge_pin;

   modport source (output valid, action, key_pressed, adc_sample, standby_pin, charge_pin,
                   input ready);
   modport sink   (input valid, action, key_pressed, adc_sample, standby_pin, charge_pin,
                   output ready);
endinterface

interface bgpk_rsp_if
   import bgpk_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   power_enable;
   logic [CHARGE_BITS-1:0] charge_status;
   logic [LEVEL_BITS-1:0]  battery_level;
   logic [CODE_BITS-1:0]   average_code;

   modport source (output valid, power_enable, charge_status, battery_level, average_code,
                   input ready);
   modport sink   (input valid, power_enable, charge_status, battery_level, average_code,
                   output ready);
endinterface

// ----- hdl/bgpk_key_ctrl.sv -----
`timescale 1ns / 1ps
// power key hold counter, press threshold register and power enable toggle
// depends on bgpk_pkg

module bgpk_key_ctrl
   import bgpk_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  key_tick,
   input  logic                  key_pressed,
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_write_data,
   output logic                  power_on
   );

   logic [COUNT_BITS-1:0] press_ticks_ff;
   logic [COUNT_BITS-1:0] hold_count_ff, hold_count_in;
   logic                  power_on_ff, power_on_in;
   logic [COUNT_BITS-1:0] hold_next;

   always_comb begin
      hold_next     = hold_count_ff + 1'b1;
      hold_count_in = hold_count_ff;
      power_on_in   = power_on_ff;
      if (key_tick) begin
         if (key_pressed) begin
            if (hold_next == press_ticks_ff) begin
               hold_count_in = '0;
               power_on_in   = ~power_on_ff;
            end else begin
               hold_count_in = hold_next;
            end
         end else begin
            hold_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ticks_ff <= PRESS_TICKS_RESET;
         hold_count_ff  <= '0;
         power_on_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            press_ticks_ff <= csr_write_data;
         end
         hold_count_ff <= hold_count_in;
         power_on_ff   <= power_on_in;
      end
   end

   assign power_on = power_on_ff;

endmodule

// ----- hdl/bgpk_monitor.sv -----
`timescale 1ns / 1ps
// monitor tick schedule: sample averaging, charger pin decode, level mapping
// depends on bgpk_pkg

module bgpk_monitor
   import bgpk_pkg::*;
   #(
   parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEFAULT,
   parameter int ADC_BITS            = ADC_BITS_DEFAULT
   )
   (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   monitor_tick,
   input  logic [SAMPLE_BITS-1:0] adc_sample,
   input  logic                   standby_pin,
   input  logic                   charge_pin,
   input  logic                   power_on,
   output bgpk_status_type        status
   );

   localparam int SUM_BITS    = ADC_BITS + 4;
   localparam int CNT_BITS    = 4;
   localparam int DIV_LOG     = $clog2(SAMPLES_PER_AVERAGE);
   localparam int RECIP_SHIFT = SUM_BITS + DIV_LOG;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam longint unsigned RECIP_VALUE =
      ((64'd1 << RECIP_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VALUE);
   localparam int UP_SHIFT    = (ADC_BITS < CODE_BITS) ? (CODE_BITS - ADC_BITS) : 0;
   localparam int DOWN_SHIFT  = (ADC_BITS > CODE_BITS) ? (ADC_BITS - CODE_BITS) : 0;
   localparam int WIDE_BITS   = ADC_MAX_BITS + CODE_BITS;

   logic [TICK_BITS-1:0]    tick_ff, tick_in;
   logic [PHASE5_BITS-1:0]  phase5_ff, phase5_in;
   logic [PHASE11_BITS-1:0] phase11_ff, phase11_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [ADC_BITS-1:0]     average_ff, average_in;
   logic [CHARGE_BITS-1:0]  charge_ff, charge_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;

   logic [ADC_MAX_BITS-1:0] sample_ext;
   logic [ADC_BITS-1:0]     sample_w;
   logic [SUM_BITS-1:0]     sum_next;
   logic [CNT_BITS:0]       count_next;
   logic [PROD_BITS-1:0]    product;
   logic [WIDE_BITS-1:0]    code_wide;
   logic [CODE_BITS-1:0]    code;
   logic [LEVEL_BITS-1:0]   level_map;
   logic [ADC_MAX_BITS-1:0] average_ext;

   assign sample_ext = ADC_MAX_BITS'(adc_sample);
   assign sample_w   = sample_ext[ADC_BITS-1:0];
   assign sum_next   = sum_ff + SUM_BITS'(sample_w);
   assign count_next = {1'b0, count_ff} + 1'b1;

   // divide by the sample count as a multiply by a rounded-up reciprocal, exact over the sum range
   assign product = PROD_BITS'(sum_next) * PROD_BITS'(RECIP);

   // average brought to the 10-bit code scale
   assign code_wide = (WIDE_BITS'(average_ff) << UP_SHIFT) >> DOWN_SHIFT;
   assign code      = code_wide[CODE_BITS-1:0];

   always_comb begin
      level_map = LEVEL_BITS'(1);
      for (int i = 1; i < LEVEL_STEPS - 1; i++) begin
         if (code > LEVEL_TOP[i]) begin
            level_map = level_map + 1'b1;
         end
      end
   end

   always_comb begin
      tick_in    = tick_ff;
      phase5_in  = phase5_ff;
      phase11_in = phase11_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      average_in = average_ff;
      charge_in  = charge_ff;
      level_in   = level_ff;
      if (monitor_tick) begin
         tick_in    = tick_ff + 1'b1;
         phase5_in  = (phase5_ff == PHASE5_BITS'(SAMPLE_PERIOD - 1)) ? '0 : phase5_ff + 1'b1;
         phase11_in = (phase11_ff == PHASE11_BITS'(CHARGE_PERIOD - 1)) ? '0
                                                                        : phase11_ff + 1'b1;
         if (phase5_in == '0) begin
            if (count_next == (CNT_BITS + 1)'(SAMPLES_PER_AVERAGE)) begin
               average_in = product[RECIP_SHIFT +: ADC_BITS];
               sum_in     = '0;
               count_in   = '0;
            end else begin
               sum_in   = sum_next;
               count_in = count_next[CNT_BITS-1:0];
            end
         end else if (phase11_in == '0) begin
            priority if (standby_pin && !charge_pin) begin
               charge_in = CHARGE_CHARGING;
            end else if (!standby_pin && charge_pin) begin
               charge_in = CHARGE_FULL;
            end else begin
               charge_in = CHARGE_NONE;
            end
         end else if (tick_in == TICK_BITS'(TICK_LAST)) begin
            // end of the schedule: restart all phases, refresh level if the code is in band
            tick_in    = '0;
            phase5_in  = '0;
            phase11_in = '0;
            if (code >= LEVEL_TOP[0] && code <= LEVEL_TOP[LEVEL_STEPS-1]) begin
               level_in = power_on ? level_map : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         phase5_ff  <= '0;
         phase11_ff <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         average_ff <= '0;
         charge_ff  <= CHARGE_NONE;
         level_ff   <= '0;
      end else begin
         tick_ff    <= tick_in;
         phase5_ff  <= phase5_in;
         phase11_ff <= phase11_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         average_ff <= average_in;
         charge_ff  <= charge_in;
         level_ff   <= level_in;
      end
   end

   assign average_ext          = ADC_MAX_BITS'(average_ff);
   assign status.charge_status = charge_ff;
   assign status.battery_level = level_ff;
   assign status.average_code  = average_ext[CODE_BITS-1:0];

endmodule

// ----- hdl/battery_gauge_power_key_monitor_unit.sv -----
`timescale 1ns / 1ps
// top level of the battery gauge and power key monitor
// depends on bgpk_pkg, bgpk_if, bgpk_key_ctrl and bgpk_monitor

// Each request is a key tick or a monitor tick and yields exactly one response,
// the power enable, charge status, battery level and latest average code as they
// stand after that tick. The key and monitor state registers are updated at the
// accepting edge and double as the response register, so the response is valid in
// the next cycle. One request per cycle is sustained; the only limit is the single
// response slot, which frees up in the same cycle that its response is taken, so a
// stalled response side stalls the request side and nothing else. The user must
// write the press threshold register through the csr port only while no request is
// in flight; the block does not enforce this. The register resets to 200 ticks.

module battery_gauge_power_key_monitor_unit
   import bgpk_pkg::*;
   #(
   parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEFAULT,
   parameter int ADC_BITS            = ADC_BITS_DEFAULT
   )
   (
   input  logic                  clock,
   input  logic                  reset,
   bgpk_req_if.sink              req_bus,
   bgpk_rsp_if.source            rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_write_data
   );

   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;
   logic            key_tick;
   logic            monitor_tick;
   logic            power_on;
   bgpk_status_type status;

   // the response slot is free when empty or being emptied this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign key_tick      = req_accept && (req_bus.action == ACTION_KEY);
   assign monitor_tick  = req_accept && (req_bus.action == ACTION_MONITOR);

   assign rsp_valid_in  = req_accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   bgpk_key_ctrl u_key_ctrl (
      .clock            (clock),
      .reset            (reset),
      .key_tick         (key_tick),
      .key_pressed      (req_bus.key_pressed),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .power_on         (power_on)
   );

   bgpk_monitor #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .ADC_BITS            (ADC_BITS)
   ) u_monitor (
      .clock        (clock),
      .reset        (reset),
      .monitor_tick (monitor_tick),
      .adc_sample   (req_bus.adc_sample),
      .standby_pin  (req_bus.standby_pin),
      .charge_pin   (req_bus.charge_pin),
      .power_on     (power_on),
      .status       (status)
   );

   // state registers hold the response until the next request is taken
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.power_enable  = power_on;
   assign rsp_bus.charge_status = status.charge_status;
   assign rsp_bus.battery_level = status.battery_level;
   assign rsp_bus.average_code  = status.average_code;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for battery_gauge_power_key_monitor_unit: table of directed requests, then random
// traffic, with responses checked against an in-bench model of the gauge; depends on bgpk_pkg
// and the request and response channel interfaces in bgpk_if

module tb;
   import bgpk_pkg::*;

   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 3;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;

   // gauge behaviour as the in-bench model sees it
   localparam int                    AVERAGE_SAMPLES = 9;
   localparam int                    SUM_BITS        = SAMPLE_BITS + 4;
   localparam int                    SAMPLE_EVERY    = 5;
   localparam int                    CHARGE_EVERY    = 11;
   localparam int                    TICK_WRAP       = 50;
   localparam logic [COUNT_BITS-1:0] PRESS_AT_RESET  = 10'd200;
   localparam int                    level_bounds [9] = '{
      716, 885, 893, 899, 912, 925, 942, 963, 1002
   };

   typedef enum logic {ROW_TICK, ROW_PRESS} row_kind_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {SHAPE_EDGE, SHAPE_BAND, SHAPE_ANY, SHAPE_OUTSIDE} sample_shape_type;

   typedef struct packed {
      logic                   action;
      logic                   key_pressed;
      logic [SAMPLE_BITS-1:0] adc_sample;
      logic                   standby_pin;
      logic                   charge_pin;
   } gauge_tick_type;

   typedef struct packed {
      logic            power_enable;
      bgpk_status_type status;
   } gauge_reading_type;

   // one row of the directed table: a request, or a new press threshold carried in operand;
   // the reading fields only count where pinned is set
   typedef struct packed {
      row_kind_type           kind;
      logic                   action;
      logic                   key_pressed;
      logic [SAMPLE_BITS-1:0] operand;
      logic                   standby_pin;
      logic                   charge_pin;
      logic                   pinned;
      logic                   power_enable;
      logic [CHARGE_BITS-1:0] charge_status;
      logic [LEVEL_BITS-1:0]  battery_level;
      logic [CODE_BITS-1:0]   average_code;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [COUNT_BITS-1:0] csr_write_data;

   bgpk_req_if req_bus ();
   bgpk_rsp_if rsp_bus ();

   battery_gauge_power_key_monitor_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // pinned expectation travels beside the request payload, so it lines up at acceptance
   logic              req_pinned;
   gauge_reading_type req_pinned_reading;

   // model state of the gauge
   logic [COUNT_BITS-1:0]  press_threshold = PRESS_AT_RESET;
   logic [COUNT_BITS-1:0]  hold_count;
   logic                   power_state;
   logic [TICK_BITS-1:0]   tick_phase;
   logic [SUM_BITS-1:0]    sample_total;
   logic [3:0]             samples_taken;
   logic [CODE_BITS-1:0]   average_now;
   logic [CHARGE_BITS-1:0] charge_now;
   logic [LEVEL_BITS-1:0]  level_now;

   gauge_reading_type expected_readings [$];
   int                requests_accepted = 0;
   int                readings_checked  = 0;
   int                fault_count       = 0;
   int                mismatch_reports  = 0;
   int                cycle_count       = 0;
   int                send_idle_pct     = 0;
   int                stall_pct         = 0;

   // --------------------------------------------------------------------------------------
   // model of the gauge: advances the state by one request and gives the reading after it
   // --------------------------------------------------------------------------------------
   function automatic gauge_reading_type advance_gauge(input gauge_tick_type t);
      gauge_reading_type reading;
      int                next_taken;
      int                lvl;
      if (t.action == ACTION_KEY) begin
         if (t.key_pressed) begin
            // count wraps at 10 bits, so a threshold below the count waits for the wrap
            hold_count = hold_count + 1'b1;
            if (hold_count == press_threshold) begin
               hold_count  = '0;
               power_state = ~power_state;
            end
         end else begin
            hold_count = '0;
         end
      end else begin
         tick_phase = tick_phase + 1'b1;
         if (tick_phase % SAMPLE_EVERY == 0) begin
            next_taken   = int'(samples_taken) + 1;
            sample_total = sample_total + t.adc_sample;
            if (next_taken == AVERAGE_SAMPLES) begin
               average_now   = CODE_BITS'(int'(sample_total) / AVERAGE_SAMPLES);
               sample_total  = '0;
               samples_taken = '0;
            end else begin
               samples_taken = 4'(next_taken);
            end
         end else if (tick_phase % CHARGE_EVERY == 0) begin
            if (t.standby_pin && !t.charge_pin)
               charge_now = CHARGE_CHARGING;
            else if (!t.standby_pin && t.charge_pin)
               charge_now = CHARGE_FULL;
            else
               charge_now = CHARGE_NONE;
         end else if (tick_phase > TICK_WRAP) begin
            tick_phase = '0;
            // codes outside the threshold band keep the old level
            if (average_now >= level_bounds[0] && average_now <= level_bounds[8]) begin
               lvl = 1;
               while (lvl < 8 && average_now > level_bounds[lvl])
                  lvl++;
               level_now = power_state ? LEVEL_BITS'(lvl) : '0;
            end
         end
      end
      reading.power_enable         = power_state;
      reading.status.charge_status = charge_now;
      reading.status.battery_level = level_now;
      reading.status.average_code  = average_now;
      return reading;
   endfunction

   // --------------------------------------------------------------------------------------
   // scoreboard: predict on each accepted request, check each accepted response in order
   // --------------------------------------------------------------------------------------
   always @(posedge clock) begin
      gauge_reading_type predicted;
      gauge_reading_type observed;
      if (reset) begin
         hold_count    = '0;
         power_state   = 1'b0;
         tick_phase    = '0;
         sample_total  = '0;
         samples_taken = '0;
         average_now   = '0;
         charge_now    = CHARGE_NONE;
         level_now     = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = advance_gauge({req_bus.action, req_bus.key_pressed, req_bus.adc_sample,
                                       req_bus.standby_pin, req_bus.charge_pin});
            // rows typed into the table replace the model's answer, the state still moves
            if (req_pinned)
               predicted = req_pinned_reading;
            expected_readings.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            observed = {rsp_bus.power_enable, rsp_bus.charge_status, rsp_bus.battery_level,
                        rsp_bus.average_code};
            if (expected_readings.size() == 0) begin
               fault_count++;
               if (mismatch_reports < REPORT_LIMIT) begin
                  mismatch_reports++;
                  $display("tb: response with no request waiting at cycle %0d", cycle_count);
               end
            end else begin
               predicted = expected_readings.pop_front();
               readings_checked++;
               if (observed.power_enable !== predicted.power_enable
                   || observed.status.charge_status !== predicted.status.charge_status
                   || observed.status.battery_level !== predicted.status.battery_level
                   || observed.status.average_code !== predicted.status.average_code) begin
                  fault_count++;
                  if (mismatch_reports < REPORT_LIMIT) begin
                     mismatch_reports++;
                     $display("tb: mismatch on response %0d: expected pwr=%0d chg=%0d lvl=%0d avg=%0d",
                              readings_checked,
                              predicted.power_enable, predicted.status.charge_status,
                              predicted.status.battery_level, predicted.status.average_code);
                     $display("tb:    got pwr=%0d chg=%0d lvl=%0d avg=%0d",
                              observed.power_enable, observed.status.charge_status,
                              observed.status.battery_level, observed.status.average_code);
                  end
               end
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------------------
   // request driving
   // --------------------------------------------------------------------------------------

   // returns at the edge where the request is taken; valid stays high for a back-to-back one
   task automatic drive_tick(input gauge_tick_type t, input logic pinned,
                             input gauge_reading_type reading);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= t.action;
      req_bus.key_pressed <= t.key_pressed;
      req_bus.adc_sample  <= t.adc_sample;
      req_bus.standby_pin <= t.standby_pin;
      req_bus.charge_pin  <= t.charge_pin;
      req_pinned          <= pinned;
      req_pinned_reading  <= reading;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      requests_accepted++;
   endtask

   // stop sending and wait until every request has its response back
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (readings_checked != requests_accepted)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_press_ticks(input logic [COUNT_BITS-1:0] setting);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      press_threshold   = setting;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 46;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 46;
         end
         default: begin
            send_idle_pct = 13;
            stall_pct     = 13;
         end
      endcase
   endtask

   // fields a key request ignores still get random values
   function automatic gauge_tick_type make_key_tick(input logic pressed);
      gauge_tick_type t;
      t.action      = ACTION_KEY;
      t.key_pressed = pressed;
      t.adc_sample  = SAMPLE_BITS'($urandom_range(1023));
      t.standby_pin = 1'($urandom_range(1));
      t.charge_pin  = 1'($urandom_range(1));
      return t;
   endfunction

   function automatic gauge_tick_type make_monitor_tick(input int sample);
      gauge_tick_type t;
      t.action      = ACTION_MONITOR;
      t.key_pressed = 1'($urandom_range(1));
      t.adc_sample  = SAMPLE_BITS'(sample);
      t.standby_pin = 1'($urandom_range(1));
      t.charge_pin  = 1'($urandom_range(1));
      return t;
   endfunction

   // a run of pressed key ticks, with monitor ticks mixed in that leave the count alone
   task automatic hold_key(input int presses, input int mix_pct);
      repeat (presses) begin
         if ($urandom_range(99) < mix_pct)
            drive_tick(make_monitor_tick($urandom_range(700, 1010)), 1'b0, '0);
         drive_tick(make_key_tick(1'b1), 1'b0, '0);
      end
   endtask

   // monitor ticks, samples around one code so the nine-sample average lands there, or all random
   task automatic monitor_burst();
      sample_shape_type shape;
      int               target;
      int               sample;
      shape = sample_shape_type'($urandom_range(3));
      case (shape)
         SHAPE_EDGE:    target = level_bounds[$urandom_range(8)] + int'($urandom_range(2)) - 1;
         SHAPE_BAND:    target = $urandom_range(700, 1010);
         SHAPE_OUTSIDE: target = ($urandom_range(1) != 0) ? $urandom_range(600, 715)
                                                           : $urandom_range(1003, 1023);
         default:       target = 0;
      endcase
      repeat ($urandom_range(5, 60)) begin
         if (shape == SHAPE_ANY) begin
            sample = $urandom_range(1023);
         end else begin
            sample = target + int'($urandom_range(4)) - 2;
            if (sample < 0)
               sample = 0;
            if (sample > 1023)
               sample = 1023;
         end
         drive_tick(make_monitor_tick(sample), 1'b0, '0);
      end
   endtask

   task automatic random_traffic(input int budget);
      int             first;
      int             pick;
      int             presses;
      gauge_tick_type t;
      first = requests_accepted;
      while (requests_accepted - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // key hold, mostly exactly long enough to toggle the power
            if (press_threshold != 0 && press_threshold <= 64 && $urandom_range(9) < 7)
               presses = press_threshold;
            else
               presses = $urandom_range(1, 12);
            hold_key(presses, 10);
            if ($urandom_range(99) < 85)
               drive_tick(make_key_tick(1'b0), 1'b0, '0);
         end else if (pick < 85) begin
            monitor_burst();
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 8)) begin
               t.action      = 1'($urandom_range(1));
               t.key_pressed = 1'($urandom_range(1));
               t.adc_sample  = SAMPLE_BITS'($urandom_range(1023));
               t.standby_pin = 1'($urandom_range(1));
               t.charge_pin  = 1'($urandom_range(1));
               drive_tick(t, 1'b0, '0);
            end
         end else begin
            // hold off until the response side has caught up completely
            settle();
         end
      end
   endtask

   task automatic run_phase(input logic [COUNT_BITS-1:0] setting, input idle_mode_type mode,
                            input int budget);
      set_press_ticks(setting);
      set_idling(mode);
      random_traffic(budget);
   endtask

   // --------------------------------------------------------------------------------------
   // directed table: threshold writes and requests, readings typed in where plain to see
   // --------------------------------------------------------------------------------------
   stim_row_type directed_rows [26] = '{
      // straight after reset everything reads zero
      '{ROW_TICK,  ACTION_KEY,     1'b0, 10'd0,    1'b0, 1'b0, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b0, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      // one-tick threshold: every press toggles
      '{ROW_PRESS, ACTION_KEY,     1'b0, 10'd1,    1'b0, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, CHARGE_NONE, 4'd0, 10'd0},
      // two-tick threshold, release in between restarts the count
      '{ROW_PRESS, ACTION_KEY,     1'b0, 10'd2,    1'b0, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b0, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_KEY,     1'b1, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, CHARGE_NONE, 4'd0, 10'd0},
      // monitor ticks 2 to 11: samples on 5 and 10, charger pins decoded on 11
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b1, 10'd512,  1'b1, 1'b1, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd682,  1'b0, 1'b1, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b1, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd341,  1'b0, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b1, 10'd1023, 1'b1, 1'b1, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b1, 10'd900,  1'b1, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0},
      '{ROW_TICK,  ACTION_MONITOR, 1'b0, 10'd0,    1'b1, 1'b0, 1'b1, 1'b1, CHARGE_CHARGING, 4'd0,
        10'd0},
      // top threshold
      '{ROW_PRESS, ACTION_KEY,     1'b0, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, CHARGE_NONE, 4'd0, 10'd0}
   };

   // --------------------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------------------
   initial begin
      gauge_tick_type    t;
      gauge_reading_type reading;

      // every driven input known from time zero, the response ready follows at the first edge
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACTION_KEY;
      req_bus.key_pressed = 1'b0;
      req_bus.adc_sample  = '0;
      req_bus.standby_pin = 1'b0;
      req_bus.charge_pin  = 1'b0;
      req_pinned          = 1'b0;
      req_pinned_reading  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_PRESS) begin
            set_press_ticks(directed_rows[i].operand);
         end else begin
            t.action                     = directed_rows[i].action;
            t.key_pressed                = directed_rows[i].key_pressed;
            t.adc_sample                 = directed_rows[i].operand;
            t.standby_pin                = directed_rows[i].standby_pin;
            t.charge_pin                 = directed_rows[i].charge_pin;
            reading.power_enable         = directed_rows[i].power_enable;
            reading.status.charge_status = directed_rows[i].charge_status;
            reading.status.battery_level = directed_rows[i].battery_level;
            reading.status.average_code  = directed_rows[i].average_code;
            drive_tick(t, directed_rows[i].pinned, reading);
         end
      end

      // random traffic across thresholds and idling patterns
      run_phase(10'd3, IDLE_NONE, 130);
      run_phase(10'd1, IDLE_SENDER, 130);
      run_phase(10'd7, IDLE_RECEIVER, 130);
      run_phase(10'd2, IDLE_BOTH, 130);

      // top threshold held one short of a toggle, then dropped to zero under the running
      // count: no toggle as the count reaches 1023, the toggle comes once it wraps to zero
      drive_tick(make_key_tick(1'b0), 1'b0, '0);
      set_press_ticks(10'd1023);
      set_idling(IDLE_SENDER);
      hold_key(1022, 2);
      set_press_ticks(10'd0);
      set_idling(IDLE_BOTH);
      hold_key(2, 0);
      drive_tick(make_key_tick(1'b0), 1'b0, '0);
      random_traffic(40);

      // drain and give the block time to show any stray response
      settle();
      repeat (4) @(posedge clock);
      if (fault_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
